@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define CHK_SAME(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_SAME(lbl, ante, cons, msg)
`define CHK_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/rssm_pkg.sv @@
// ---------------------------------------------------------------------------
// rssm_pkg
// constants, types and codes shared by the room streaming set manager
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rssm_pkg;

	localparam int MAX_ROOMS  = 64;
	localparam int ROOM_W     = $clog2(MAX_ROOMS);
	localparam int IDX_W      = $clog2(MAX_ROOMS + 1);
	localparam int LOAD_SLOTS = 8;
	localparam int LD_W       = $clog2(LOAD_SLOTS);
	localparam int CNT_W      = $clog2(LOAD_SLOTS + 1);
	localparam int MAX_NB     = 8;
	localparam int NB_W       = $clog2(MAX_NB);
	localparam int NBC_W      = $clog2(MAX_NB + 1);
	localparam int COORD_W    = 32;
	localparam int NB_ID_W    = 8;
	localparam int RC_W       = 7;
	localparam int ML_W       = 4;
	localparam int BH_W       = 31;
	localparam int CFG_W      = 31;

	// request codes
	localparam logic [1:0] REQ_BOUNDS = 2'd0;
	localparam logic [1:0] REQ_NEIGH  = 2'd1;
	localparam logic [1:0] REQ_CAMERA = 2'd2;

	// result kinds
	localparam logic [1:0] EV_UNLOAD = 2'd0;
	localparam logic [1:0] EV_LOAD   = 2'd1;
	localparam logic [1:0] EV_DONE   = 2'd2;

	// register indexes
	localparam logic [1:0] CFG_NUM_ROOMS = 2'd0;
	localparam logic [1:0] CFG_LOAD_CAP  = 2'd1;
	localparam logic [1:0] CFG_BOX_HALF  = 2'd2;

	localparam logic [ML_W-1:0] LOAD_CAP_RST = 4'd8;
	localparam logic [BH_W-1:0] BOX_HALF_RST = 31'd5120;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [ROOM_W-1:0] room_t;

	typedef struct packed {
		coord_t x0;
		coord_t y0;
		coord_t z0;
		coord_t x1;
		coord_t y1;
		coord_t z1;
	} box_t;

	// controller to datapath commands
	typedef struct packed {
		logic wr_bnd;
		logic wr_nb;
		logic cam_start;
		logic idx_clr;
		logic idx_inc;
		logic act_rd;
		logic scan_chk;
		logic scan_meets;
		logic seed_begin;
		logic seed_inc;
		logic cnt_latch;
		logic nb_chk;
		logic unload_step;
		logic load_step;
		logic act_chk;
		logic emit_done;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_end;
		logic seed_end;
		logic nb_end;
		logic ld_end;
		logic des_end;
		logic load_full;
	} stat_t;

endpackage
`default_nettype wire

@@ sv/rssm_ram.sv @@
// ---------------------------------------------------------------------------
// rssm_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rssm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ sv/rssm_ctrl.sv @@
// ---------------------------------------------------------------------------
// rssm_ctrl
// sequencer for table writes and the camera update passes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rssm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    req_type,
	input  wire rssm_pkg::stat_t st,
	output rssm_pkg::cmd_t     cmd,
	output logic               busy
);
	import rssm_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE      = 13'b0000000000001,
		S_SCAN0_RD  = 13'b0000000000010,
		S_SCAN0_CHK = 13'b0000000000100,
		S_SCAN1_RD  = 13'b0000000001000,
		S_SCAN1_CHK = 13'b0000000010000,
		S_NB_SEED   = 13'b0000000100000,
		S_NB_CNT    = 13'b0000001000000,
		S_NB_RD     = 13'b0000010000000,
		S_NB_CHK    = 13'b0000100000000,
		S_UNLOAD    = 13'b0001000000000,
		S_LOAD      = 13'b0010000000000,
		S_ACT_RD    = 13'b0100000000000,
		S_ACT_CHK   = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req_type)
						REQ_BOUNDS: cmd.wr_bnd = 1'b1;
						REQ_NEIGH:  cmd.wr_nb = 1'b1;
						REQ_CAMERA: begin
							cmd.cam_start = 1'b1;
							state_d       = S_SCAN0_RD;
						end
						default: ;
					endcase
				end
			end
			S_SCAN0_RD: begin
				if (st.scan_end) begin
					cmd.idx_clr = 1'b1;
					state_d     = S_SCAN1_RD;
				end else begin
					state_d = S_SCAN0_CHK;
				end
			end
			S_SCAN0_CHK: begin
				cmd.scan_chk = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = S_SCAN0_RD;
			end
			S_SCAN1_RD: begin
				if (st.scan_end) begin
					cmd.seed_begin = 1'b1;
					state_d        = S_NB_SEED;
				end else begin
					state_d = S_SCAN1_CHK;
				end
			end
			S_SCAN1_CHK: begin
				cmd.scan_chk   = 1'b1;
				cmd.scan_meets = 1'b1;
				cmd.idx_inc    = 1'b1;
				state_d        = S_SCAN1_RD;
			end
			S_NB_SEED: begin
				if (st.seed_end) begin
					cmd.idx_clr = 1'b1;
					state_d     = S_UNLOAD;
				end else begin
					state_d = S_NB_CNT;
				end
			end
			S_NB_CNT: begin
				cmd.cnt_latch = 1'b1;
				state_d       = S_NB_RD;
			end
			S_NB_RD: begin
				if (st.nb_end) begin
					cmd.seed_inc = 1'b1;
					state_d      = S_NB_SEED;
				end else begin
					state_d = S_NB_CHK;
				end
			end
			S_NB_CHK: begin
				cmd.nb_chk = 1'b1;
				state_d    = S_NB_RD;
			end
			S_UNLOAD: begin
				if (st.ld_end) begin
					cmd.idx_clr = 1'b1;
					state_d     = S_LOAD;
				end else begin
					cmd.unload_step = 1'b1;
				end
			end
			S_LOAD: begin
				if (st.des_end || st.load_full) begin
					cmd.idx_clr = 1'b1;
					state_d     = S_ACT_RD;
				end else begin
					cmd.load_step = 1'b1;
				end
			end
			S_ACT_RD: begin
				cmd.act_rd = 1'b1;
				if (st.ld_end) begin
					cmd.emit_done = 1'b1;
					state_d       = S_IDLE;
				end else begin
					state_d = S_ACT_CHK;
				end
			end
			S_ACT_CHK: begin
				cmd.act_rd  = 1'b1;
				cmd.act_chk = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_ACT_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

@@ sv/rssm_dp.sv @@
// ---------------------------------------------------------------------------
// rssm_dp
// room tables, desired and loaded lists, box tests and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rssm_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rssm_pkg::cmd_t       cmd,
	output rssm_pkg::stat_t           st,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [30:0]          cfg_data,
	input  wire logic [5:0]           room_index,
	input  wire logic signed [31:0]   px,
	input  wire logic signed [31:0]   py,
	input  wire logic signed [31:0]   pz,
	input  wire logic signed [31:0]   qx,
	input  wire logic signed [31:0]   qy,
	input  wire logic signed [31:0]   qz,
	input  wire logic [2:0]           neighbour_slot,
	input  wire logic [7:0]           neighbour_id,
	input  wire logic [3:0]           neighbour_total,
	output logic                      result_valid,
	output logic [1:0]                event_kind,
	output logic [5:0]                room_id,
	output logic                      active_valid,
	output logic [5:0]                active_id,
	output logic                      last
);
	import rssm_pkg::*;

	// list membership over the valid part of a list
	function automatic logic member(input room_t lst [LOAD_SLOTS],
			input logic [CNT_W-1:0] tot, input room_t x);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < LOAD_SLOTS; k++) begin
			if ((CNT_W'(k) < tot) && (lst[k] == x)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// camera coordinate plus or minus half size, saturated
	function automatic coord_t sat_add(input coord_t a, input logic [BH_W-1:0] b,
			input logic neg);
		logic signed [COORD_W+1:0] ea;
		logic signed [COORD_W+1:0] eb;
		logic signed [COORD_W+1:0] s;
		coord_t r;
		ea = {{2{a[COORD_W-1]}}, a};
		eb = {{(COORD_W+2-BH_W){1'b0}}, b};
		s  = neg ? (ea - eb) : (ea + eb);
		if (s[COORD_W+1:COORD_W-1] == 3'b000 || s[COORD_W+1:COORD_W-1] == 3'b111) begin
			r = s[COORD_W-1:0];
		end else if (s[COORD_W+1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	// configuration registers
	logic [RC_W-1:0] num_rooms_q;
	logic [ML_W-1:0] load_cap_q;
	logic [BH_W-1:0] box_half_q;

	// camera registers
	coord_t cam_x_q, cam_y_q, cam_z_q;
	coord_t lo_x_q, lo_y_q, lo_z_q;
	coord_t hi_x_q, hi_y_q, hi_z_q;

	// lists and counters
	room_t             des_q [LOAD_SLOTS];
	room_t             ld_q  [LOAD_SLOTS];
	logic [CNT_W-1:0]  des_tot_q, ld_tot_q, seeds_q, seed_q;
	logic [IDX_W-1:0]  idx_q;
	logic [NBC_W-1:0]  nbj_q, nb_cnt_q;
	logic              av_q;
	room_t             ar_q;
	logic [MAX_ROOMS-1:0] cnt_vld_q;
	logic              cnt_vld_rd_q;

	// memory ports
	box_t              bnd_rdata;
	room_t             bnd_raddr;
	logic [NB_ID_W-1:0] nb_rdata;
	logic [NBC_W-1:0]  cnt_rdata;
	logic [NBC_W-1:0]  cnt_wdata;
	room_t             seed_room;

	// clamped registers
	logic [RC_W-1:0]   rooms;
	logic [CNT_W-1:0]  cap;

	assign rooms = (num_rooms_q > RC_W'(MAX_ROOMS)) ? RC_W'(MAX_ROOMS) : num_rooms_q;
	assign cap   = (CNT_W'(load_cap_q) > CNT_W'(LOAD_SLOTS)) ? CNT_W'(LOAD_SLOTS)
		: CNT_W'(load_cap_q);
	assign cnt_wdata = (NBC_W'(neighbour_total) > NBC_W'(MAX_NB)) ? NBC_W'(MAX_NB)
		: NBC_W'(neighbour_total);

	assign seed_room = des_q[seed_q[LD_W-1:0]];
	assign bnd_raddr = cmd.act_rd ? ld_q[idx_q[LD_W-1:0]] : idx_q[ROOM_W-1:0];

	rssm_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_ROOMS)) u_bnd_ram (
		.clk   (clk),
		.we    (cmd.wr_bnd),
		.waddr (room_index),
		.wdata ({px, py, pz, qx, qy, qz}),
		.raddr (bnd_raddr),
		.rdata (bnd_rdata)
	);

	rssm_ram #(.WIDTH(NB_ID_W), .DEPTH(MAX_ROOMS * MAX_NB)) u_nb_ram (
		.clk   (clk),
		.we    (cmd.wr_nb),
		.waddr ({room_index, neighbour_slot}),
		.wdata (neighbour_id),
		.raddr ({seed_room, nbj_q[NB_W-1:0]}),
		.rdata (nb_rdata)
	);

	rssm_ram #(.WIDTH(NBC_W), .DEPTH(MAX_ROOMS)) u_cnt_ram (
		.clk   (clk),
		.we    (cmd.wr_nb),
		.waddr (room_index),
		.wdata (cnt_wdata),
		.raddr (seed_room),
		.rdata (cnt_rdata)
	);

	// box tests on the room read last cycle
	logic has_pt, meets_box;
	assign has_pt = (cam_x_q >= bnd_rdata.x0) && (cam_x_q <= bnd_rdata.x1)
		&& (cam_y_q >= bnd_rdata.y0) && (cam_y_q <= bnd_rdata.y1)
		&& (cam_z_q >= bnd_rdata.z0) && (cam_z_q <= bnd_rdata.z1);
	assign meets_box = (lo_x_q <= bnd_rdata.x1) && (hi_x_q >= bnd_rdata.x0)
		&& (lo_y_q <= bnd_rdata.y1) && (hi_y_q >= bnd_rdata.y0)
		&& (lo_z_q <= bnd_rdata.z1) && (hi_z_q >= bnd_rdata.z0);

	// candidate ids and membership
	room_t scan_id, nb_room, ld_cur, des_cur;
	logic  scan_hit, scan_new, nb_new, ld_kept, des_loaded;
	assign scan_id  = idx_q[ROOM_W-1:0];
	assign nb_room  = nb_rdata[ROOM_W-1:0];
	assign ld_cur   = ld_q[idx_q[LD_W-1:0]];
	assign des_cur  = des_q[idx_q[LD_W-1:0]];
	assign scan_hit = cmd.scan_meets ? meets_box : has_pt;
	assign scan_new = scan_hit && !member(des_q, des_tot_q, scan_id);
	assign nb_new   = (nb_rdata < NB_ID_W'(rooms)) && !member(des_q, des_tot_q, nb_room);
	assign ld_kept  = member(des_q, des_tot_q, ld_cur);
	assign des_loaded = member(ld_q, ld_tot_q, des_cur);

	// status to the controller
	assign st.scan_end  = (idx_q >= IDX_W'(rooms)) || (des_tot_q >= cap);
	assign st.seed_end  = (seed_q >= seeds_q);
	assign st.nb_end    = (nbj_q >= nb_cnt_q) || (des_tot_q >= cap);
	assign st.ld_end    = (idx_q >= IDX_W'(ld_tot_q));
	assign st.des_end   = (idx_q >= IDX_W'(des_tot_q));
	assign st.load_full = !des_loaded && (ld_tot_q >= CNT_W'(LOAD_SLOTS));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rooms_q <= '0;
			load_cap_q  <= LOAD_CAP_RST;
			box_half_q  <= BOX_HALF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_ROOMS: num_rooms_q <= cfg_data[RC_W-1:0];
				CFG_LOAD_CAP:  load_cap_q  <= cfg_data[ML_W-1:0];
				CFG_BOX_HALF:  box_half_q  <= cfg_data[BH_W-1:0];
				default: ;
			endcase
		end
	end

	// neighbour count valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q    <= '0;
			cnt_vld_rd_q <= 1'b0;
		end else begin
			if (cmd.wr_nb) begin
				cnt_vld_q[room_index] <= 1'b1;
			end
			cnt_vld_rd_q <= cnt_vld_q[seed_room];
		end
	end

	// camera point and saturated box
	always_ff @(posedge clk) begin
		if (cmd.cam_start) begin
			cam_x_q <= px;
			cam_y_q <= py;
			cam_z_q <= pz;
			lo_x_q  <= sat_add(px, box_half_q, 1'b1);
			lo_y_q  <= sat_add(py, box_half_q, 1'b1);
			lo_z_q  <= sat_add(pz, box_half_q, 1'b1);
			hi_x_q  <= sat_add(px, box_half_q, 1'b0);
			hi_y_q  <= sat_add(py, box_half_q, 1'b0);
			hi_z_q  <= sat_add(pz, box_half_q, 1'b0);
		end
	end

	// list contents
	always_ff @(posedge clk) begin
		if (cmd.scan_chk && scan_new) begin
			des_q[des_tot_q[LD_W-1:0]] <= scan_id;
		end
		if (cmd.nb_chk && nb_new) begin
			des_q[des_tot_q[LD_W-1:0]] <= nb_room;
		end
		if (cmd.unload_step && !ld_kept) begin
			for (int k = 0; k < LOAD_SLOTS - 1; k++) begin
				if (IDX_W'(k) >= idx_q) begin
					ld_q[k] <= ld_q[k+1];
				end
			end
		end
		if (cmd.load_step && !des_loaded) begin
			ld_q[ld_tot_q[LD_W-1:0]] <= des_cur;
		end
	end

	// counters, totals and active room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			des_tot_q <= '0;
			ld_tot_q  <= '0;
			seeds_q   <= '0;
			seed_q    <= '0;
			idx_q     <= '0;
			nbj_q     <= '0;
			nb_cnt_q  <= '0;
			av_q      <= 1'b0;
			ar_q      <= '0;
		end else begin
			if (cmd.cam_start) begin
				des_tot_q <= '0;
				idx_q     <= '0;
				av_q      <= 1'b0;
				ar_q      <= '0;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if ((cmd.scan_chk && scan_new) || (cmd.nb_chk && nb_new)) begin
				des_tot_q <= des_tot_q + 1'b1;
			end
			if (cmd.seed_begin) begin
				seeds_q <= des_tot_q;
				seed_q  <= '0;
			end
			if (cmd.seed_inc) begin
				seed_q <= seed_q + 1'b1;
			end
			if (cmd.cnt_latch) begin
				nb_cnt_q <= cnt_vld_rd_q ? cnt_rdata : '0;
				nbj_q    <= '0;
			end
			if (cmd.nb_chk) begin
				nbj_q <= nbj_q + 1'b1;
			end
			if (cmd.unload_step) begin
				if (ld_kept) begin
					idx_q <= idx_q + 1'b1;
				end else begin
					ld_tot_q <= ld_tot_q - 1'b1;
				end
			end
			if (cmd.load_step) begin
				idx_q <= idx_q + 1'b1;
				if (!des_loaded) begin
					ld_tot_q <= ld_tot_q + 1'b1;
				end
			end
			if (cmd.act_chk && has_pt && (!av_q || (ld_cur < ar_q))) begin
				av_q <= 1'b1;
				ar_q <= ld_cur;
			end
		end
	end

	// result register
	logic emit_unload, emit_load;
	assign emit_unload = cmd.unload_step && !ld_kept;
	assign emit_load   = cmd.load_step && !des_loaded;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= emit_unload || emit_load || cmd.emit_done;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_unload) begin
			event_kind   <= EV_UNLOAD;
			room_id      <= ld_cur;
			active_valid <= 1'b0;
			active_id    <= '0;
			last         <= 1'b0;
		end else if (emit_load) begin
			event_kind   <= EV_LOAD;
			room_id      <= des_cur;
			active_valid <= 1'b0;
			active_id    <= '0;
			last         <= 1'b0;
		end else begin
			event_kind   <= EV_DONE;
			room_id      <= '0;
			active_valid <= av_q;
			active_id    <= ar_q;
			last         <= 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ sv/room_streaming_set_manager.sv @@
// Writes of bounds or neighbour entries are taken while idle and give no result.
// A camera item scans the rooms for the point, then for the camera box, reads
// the neighbours of each seed, walks the loaded and desired entries and then
// searches the loaded rooms for the active one; the room bounds memory has a
// single read port. One item at a time; results are strobed one per cycle and
// the receiver cannot stall. Async reset clears control and counter registers.
// ---------------------------------------------------------------------------
// room_streaming_set_manager
// builds the desired room set per camera item and streams unload, load and done items
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module room_streaming_set_manager (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         req_type,
	input  wire logic [5:0]         room_index,
	input  wire logic signed [31:0] px,
	input  wire logic signed [31:0] py,
	input  wire logic signed [31:0] pz,
	input  wire logic signed [31:0] qx,
	input  wire logic signed [31:0] qy,
	input  wire logic signed [31:0] qz,
	input  wire logic [2:0]         neighbour_slot,
	input  wire logic [7:0]         neighbour_id,
	input  wire logic [3:0]         neighbour_total,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [30:0]        cfg_data,
	output logic                    result_valid,
	output logic [1:0]              event_kind,
	output logic [5:0]              room_id,
	output logic                    active_valid,
	output logic [5:0]              active_id,
	output logic                    last
);
	import rssm_pkg::*;

	cmd_t  cmd;
	stat_t st;

	// sequencer
	rssm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.st       (st),
		.cmd      (cmd),
		.busy     (busy)
	);

	// tables, lists and result register
	rssm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.room_index      (room_index),
		.px              (px),
		.py              (py),
		.pz              (pz),
		.qx              (qx),
		.qy              (qy),
		.qz              (qz),
		.neighbour_slot  (neighbour_slot),
		.neighbour_id    (neighbour_id),
		.neighbour_total (neighbour_total),
		.result_valid    (result_valid),
		.event_kind      (event_kind),
		.room_id         (room_id),
		.active_valid    (active_valid),
		.active_id       (active_id),
		.last            (last)
	);

	// the done item closes the update, all others arrive mid-update
	`CHK_SAME(a_done_idle, result_valid && last, !busy, "done item while still busy")
	`CHK_SAME(a_mid_busy, result_valid && !last, busy, "load or unload item after update end")
	`CHK_SAME(a_fall_done, $fell(busy), result_valid && last, "update ended without done item")
	`CHK_NEXT(a_cam_busy, start && !busy && req_type == REQ_CAMERA, busy,
		"camera item not taken up")

endmodule
`default_nettype wire

@@ sim/tb_room_streaming_set_manager.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_room_streaming_set_manager
// drives table writes, camera items and register writes into the room set
// manager, predicts every unload, load and done result and checks them in order
// ---------------------------------------------------------------------------
module tb_room_streaming_set_manager;
	import rssm_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 340;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam longint COORD_HI = 64'sd2147483647;
	localparam longint COORD_LO = -64'sd2147483648;

	typedef struct packed {
		logic [1:0] req;
		logic [5:0] idx;
		coord_t     px, py, pz, qx, qy, qz;
		logic [2:0] slot;
		logic [7:0] nid;
		logic [3:0] ntot;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		room_t      id;
		logic       av;
		room_t      ar;
		logic       last;
	} event_t;

	// one row of the directed table: an item or a register write
	typedef struct {
		bit          is_cfg;
		item_t       it;
		bit          typed;
		bit          t_av;
		room_t       t_ar;
		logic [1:0]  cfg_idx;
		logic [30:0] cfg_val;
	} row_t;

	logic clk, arst_n, start, busy, cfg_we;
	logic [1:0] req_type, cfg_index;
	logic [5:0] room_index;
	logic signed [31:0] px, py, pz, qx, qy, qz;
	logic [2:0] neighbour_slot;
	logic [7:0] neighbour_id;
	logic [3:0] neighbour_total;
	logic [30:0] cfg_data;
	logic result_valid, active_valid, last;
	logic [1:0] event_kind;
	logic [5:0] room_id, active_id;

	room_streaming_set_manager u_top (.*);

	// predicted block state
	longint bmin [3][64];
	longint bmax [3][64];
	byte unsigned nb_tab [64][8];
	bit [7:0] nb_written [64];
	int nb_count [64];
	int loaded [$];
	int desired [$];
	int num_rooms_r, load_cap_r;
	longint box_half_r;

	event_t pending_events [$];
	row_t directed [$];
	int errors;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report(input string what, input int want, input int got);
		$display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		event_t e;
		if (arst_n && result_valid) begin
			if (pending_events.size() == 0) begin
				report("unexpected result, kind", -1, event_kind);
			end else begin
				e = pending_events.pop_front();
				if (event_kind !== e.kind) report("event_kind", e.kind, event_kind);
				if (room_id !== e.id) report("room_id", e.id, room_id);
				if (active_valid !== e.av) report("active_valid", e.av, active_valid);
				if (active_id !== e.ar) report("active_id", e.ar, active_id);
				if (last !== e.last) report("last", e.last, last);
			end
		end
	end

	function automatic bit has_point(int r, longint p[3]);
		for (int a = 0; a < 3; a++)
			if (p[a] < bmin[a][r] || p[a] > bmax[a][r]) return 0;
		return 1;
	endfunction

	function automatic bit meets_box(int r, longint lo[3], longint hi[3]);
		for (int a = 0; a < 3; a++)
			if (lo[a] > bmax[a][r] || hi[a] < bmin[a][r]) return 0;
		return 1;
	endfunction

	function automatic bit listed(int q[$], int id);
		foreach (q[k]) if (q[k] == id) return 1;
		return 0;
	endfunction

	function automatic longint clamp_coord(longint v);
		if (v > COORD_HI) return COORD_HI;
		if (v < COORD_LO) return COORD_LO;
		return v;
	endfunction

	function automatic void push_event(logic [1:0] kind, int id, bit av, int ar, bit lst);
		event_t e;
		e.kind = kind;
		e.id   = room_t'(id);
		e.av   = av;
		e.ar   = room_t'(ar);
		e.last = lst;
		pending_events.push_back(e);
	endfunction

	// predict the results of one accepted item and update the state
	task automatic predict_item(input item_t it, input bit typed, input bit t_av, input room_t t_ar);
		longint p[3], lo[3], hi[3];
		int rooms, cap, seeds, nb, i, ar;
		bit av, hit;
		case (it.req)
			REQ_BOUNDS: begin
				bmin[0][it.idx] = it.px; bmin[1][it.idx] = it.py; bmin[2][it.idx] = it.pz;
				bmax[0][it.idx] = it.qx; bmax[1][it.idx] = it.qy; bmax[2][it.idx] = it.qz;
			end
			REQ_NEIGH: begin
				nb_tab[it.idx][it.slot] = it.nid;
				nb_written[it.idx][it.slot] = 1'b1;
				nb_count[it.idx] = it.ntot > 8 ? 8 : it.ntot;
			end
			REQ_CAMERA: begin
				rooms = num_rooms_r < MAX_ROOMS ? num_rooms_r : MAX_ROOMS;
				cap = load_cap_r < LOAD_SLOTS ? load_cap_r : LOAD_SLOTS;
				p[0] = it.px; p[1] = it.py; p[2] = it.pz;
				for (int a = 0; a < 3; a++) begin
					lo[a] = clamp_coord(p[a] - box_half_r);
					hi[a] = clamp_coord(p[a] + box_half_r);
				end
				// rooms holding the point, then rooms meeting the camera box
				desired.delete();
				for (int pass = 0; pass < 2; pass++)
					for (int r = 0; r < rooms && desired.size() < cap; r++) begin
						hit = pass == 0 ? has_point(r, p) : meets_box(r, lo, hi);
						if (hit && !listed(desired, r)) desired.push_back(r);
					end
				// neighbours of the seed rooms
				seeds = desired.size();
				for (int s = 0; s < seeds; s++)
					for (int j = 0; j < nb_count[desired[s]] && desired.size() < cap; j++) begin
						nb = nb_tab[desired[s]][j];
						if (nb < rooms && !listed(desired, nb)) desired.push_back(nb);
					end
				// unload what is no longer wanted
				i = 0;
				while (i < loaded.size()) begin
					if (listed(desired, loaded[i])) i++;
					else begin
						if (!typed) push_event(EV_UNLOAD, loaded[i], 0, 0, 0);
						loaded.delete(i);
					end
				end
				// load what is wanted and missing
				foreach (desired[k]) begin
					if (listed(loaded, desired[k])) continue;
					if (loaded.size() >= LOAD_SLOTS) break;
					if (!typed) push_event(EV_LOAD, desired[k], 0, 0, 0);
					loaded.push_back(desired[k]);
				end
				av = 0; ar = 0;
				foreach (loaded[k])
					if (has_point(loaded[k], p) && (!av || loaded[k] < ar)) begin
						av = 1; ar = loaded[k];
					end
				if (typed) push_event(EV_DONE, 0, t_av, t_ar, 1);
				else push_event(EV_DONE, 0, av, ar, 1);
			end
			default: ;
		endcase
	endtask

	// hand one item over, holding start until the block takes it
	task automatic send_item(input item_t it, input int gap, input bit typed = 0,
		input bit t_av = 0, input room_t t_ar = '0);
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type = it.req; room_index = it.idx;
		px = it.px; py = it.py; pz = it.pz; qx = it.qx; qy = it.qy; qz = it.qz;
		neighbour_slot = it.slot; neighbour_id = it.nid; neighbour_total = it.ntot;
		start = 1'b1;
		do @(posedge clk); while (busy);
		predict_item(it, typed, t_av, t_ar);
	endtask

	// wait until every predicted result is in and the block is quiet
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		@(negedge clk);
		while (busy) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
		drain();
		cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_NUM_ROOMS: num_rooms_r = val[6:0];
			CFG_LOAD_CAP:  load_cap_r = val[3:0];
			CFG_BOX_HALF:  box_half_r = val;
			default: ;
		endcase
	endtask

	function automatic item_t camera(coord_t x, coord_t y, coord_t z);
		item_t it = '0;
		it.req = REQ_CAMERA; it.px = x; it.py = y; it.pz = z;
		return it;
	endfunction

	function automatic item_t bounds(int r, coord_t x0, coord_t y0, coord_t z0,
		coord_t x1, coord_t y1, coord_t z1);
		item_t it = '0;
		it.req = REQ_BOUNDS; it.idx = r;
		it.px = x0; it.py = y0; it.pz = z0; it.qx = x1; it.qy = y1; it.qz = z1;
		return it;
	endfunction

	function automatic item_t neighbour(int r, int slot, int id, int tot);
		item_t it = '0;
		it.req = REQ_NEIGH; it.idx = r; it.slot = slot; it.nid = id; it.ntot = tot;
		return it;
	endfunction

	function automatic void add_row(item_t it, bit typed = 0, bit t_av = 0, room_t t_ar = '0);
		row_t r;
		r.is_cfg = 0; r.it = it; r.typed = typed; r.t_av = t_av; r.t_ar = t_ar;
		directed.push_back(r);
	endfunction

	function automatic void add_cfg(logic [1:0] idx, logic [30:0] val);
		row_t r;
		r.is_cfg = 1; r.cfg_idx = idx; r.cfg_val = val;
		directed.push_back(r);
	endfunction

	// random bounds write: mostly small boxes near the origin
	function automatic item_t random_bounds();
		int sel = $urandom_range(0, 99);
		coord_t lo[3], hi[3];
		for (int a = 0; a < 3; a++) begin
			lo[a] = $urandom_range(0, 80000) - 40000;
			hi[a] = lo[a] + $urandom_range(0, 20000);
			if (sel < 8) begin
				lo[a] = $urandom; hi[a] = $urandom;
			end else if (sel < 16 && a == 0) begin
				hi[a] = lo[a] - 1 - $urandom_range(0, 500);
			end
		end
		return bounds($urandom_range(0, 63), lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
	endfunction

	// neighbour counts only ever cover slots that hold a value
	function automatic item_t random_neighbour();
		int r = $urandom_range(0, 63);
		int slot = $urandom_range(0, 7);
		int id = $urandom_range(0, 9) < 7 ? $urandom_range(0, 63) : $urandom_range(0, 255);
		bit [7:0] mask = nb_written[r];
		int prefix = 0;
		int tot;
		mask[slot] = 1'b1;
		while (prefix < 8 && mask[prefix]) prefix++;
		tot = $urandom_range(0, prefix);
		if (prefix == 8 && $urandom_range(0, 3) == 0) tot = $urandom_range(8, 15);
		return neighbour(r, slot, id, tot);
	endfunction

	// camera mostly inside or beside a stored box
	function automatic item_t random_camera();
		int r = $urandom_range(0, 63);
		coord_t c[3];
		longint span;
		for (int a = 0; a < 3; a++) begin
			span = bmax[a][r] - bmin[a][r];
			if ($urandom_range(0, 9) == 0) c[a] = $urandom;
			else if (span < 0 || span > 100000) c[a] = bmin[a][r];
			else c[a] = bmin[a][r] + $urandom_range(0, span) + $urandom_range(0, 8000) - 4000;
		end
		return camera(c[0], c[1], c[2]);
	endfunction

	initial begin
		item_t it;
		int gap, sel;
		errors = 0; cycles = 0;
		arst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = CFG_NUM_ROOMS; cfg_data = '0;
		req_type = REQ_BOUNDS; room_index = '0;
		px = '0; py = '0; pz = '0; qx = '0; qy = '0; qz = '0;
		neighbour_slot = '0; neighbour_id = '0; neighbour_total = '0;
		num_rooms_r = 0; load_cap_r = LOAD_CAP_RST; box_half_r = BOX_HALF_RST;
		foreach (nb_count[r]) begin
			nb_count[r] = 0; nb_written[r] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part: empty table first, then a few rooms, one spanning the full range
		add_row(camera(0, 0, 0), 1, 0, 0);
		add_row(camera(32'sh7fffffff, 32'sh80000000, 0), 1, 0, 0);
		add_cfg(CFG_BOX_HALF, 31'h7fffffff);
		add_row(camera(32'sh7fffffff, 32'sh80000000, 1), 1, 0, 0);
		add_row(bounds(0, -1000, -1000, -1000, 1000, 1000, 1000));
		add_row(bounds(1, 500, 500, 500, 3000, 3000, 3000));
		add_row(bounds(2, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
		add_row(bounds(3, 1000, -1000, -1000, -1000, 1000, 1000));
		add_row(bounds(63, 0, 0, 0, 10, 10, 10));
		add_row(neighbour(0, 0, 3, 1));
		add_row(neighbour(0, 1, 200, 2));
		add_row(neighbour(1, 0, 0, 1));
		add_row(neighbour(3, 0, 63, 1));
		add_cfg(CFG_BOX_HALF, 0);
		add_cfg(CFG_NUM_ROOMS, 4);
		add_row(camera(0, 0, 0));
		add_row(camera(2000, 2000, 2000));
		add_cfg(CFG_LOAD_CAP, 1);
		add_row(camera(0, 0, 0));
		add_cfg(CFG_LOAD_CAP, 0);
		add_row(camera(0, 0, 0));
		it = camera(5, 5, 5);
		it.req = REQ_UNUSED;
		add_row(it);
		add_cfg(CFG_LOAD_CAP, LOAD_CAP_RST);
		add_cfg(CFG_BOX_HALF, BOX_HALF_RST);
		add_row(camera(1010, 0, 0));
		foreach (directed[k]) begin
			if (directed[k].is_cfg) write_reg(directed[k].cfg_idx, directed[k].cfg_val);
			else send_item(directed[k].it, 0, directed[k].typed, directed[k].t_av,
				directed[k].t_ar);
		end

		// fill the rest of the bounds table so any room count is safe
		for (int r = 4; r < 63; r++) begin
			it = random_bounds();
			it.idx = r;
			send_item(it, $urandom_range(0, 2));
		end

		// random part, with register phases between blocks of items
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0) begin
				case ((n / 60) % 5)
					0: write_reg(CFG_NUM_ROOMS, 64);
					1: write_reg(CFG_NUM_ROOMS, 127);
					2: write_reg(CFG_NUM_ROOMS, 0);
					default: write_reg(CFG_NUM_ROOMS, $urandom_range(1, 127));
				endcase
				case ((n / 60) % 4)
					0: write_reg(CFG_LOAD_CAP, 15);
					1: write_reg(CFG_LOAD_CAP, 0);
					2: write_reg(CFG_LOAD_CAP, 8);
					default: write_reg(CFG_LOAD_CAP, $urandom_range(1, 15));
				endcase
				case ((n / 60) % 3)
					0: write_reg(CFG_BOX_HALF, $urandom_range(0, 20000));
					1: write_reg(CFG_BOX_HALF, (n / 60) % 2 ? 31'h7fffffff : 31'd0);
					default: write_reg(CFG_BOX_HALF, $urandom);
				endcase
			end
			// sender holds off until the block has caught up
			if (n == RANDOM_ITEMS / 2) drain();
			sel = $urandom_range(0, 99);
			if (sel < 45) it = random_camera();
			else if (sel < 75) it = random_bounds();
			else if (sel < 95) it = random_neighbour();
			else begin
				it = random_camera();
				it.req = REQ_UNUSED;
			end
			// stretches with no idling between stretches with random gaps
			gap = (n / 40) % 3 == 1 ? 0 : $urandom_range(0, 8);
			send_item(it, gap);
		end

		@(negedge clk);
		start = 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ room_streaming_set_manager.f @@
+incdir+sv
sv/rssm_pkg.sv
sv/rssm_ram.sv
sv/rssm_ctrl.sv
sv/rssm_dp.sv
sv/room_streaming_set_manager.sv
sim/tb_room_streaming_set_manager.sv
